// ===== sv/sorted_array_priority_queue_core_defines.svh =====
// assertion macros used by the priority queue core
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// shared types and constants for the sorted array priority queue
package spq_pkg;

  localparam int SPQ_DEPTH_DEF = 16;
  localparam int SPQ_DATA_W    = 32;
  localparam int SPQ_STAT_W    = 2;
  localparam int SPQ_OCC_W     = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_t;

  typedef enum logic [SPQ_STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } spq_stat_t;

  // what a cell hands to its neighbor away from the head
  typedef struct packed {
    logic                         shift;
    logic signed [SPQ_DATA_W-1:0] entry;
  } spq_link_t;

endpackage

// ===== sv/sorted_array_priority_queue_core.sv =====
// top level of the sorted array priority queue, smallest value removed first
//
//   port group   direction  handshake           payload
//   in_*         input      in_valid/in_stall   operation, value
//   out_*        output     out_valid/out_stall removed_value, status, occupancy
//
// one item per cycle: every cell compares against the new value and shifts in the
// same cycle, so an item is accepted each cycle that the output register is free.
// the result is registered and shows in the output register in the cycle after acceptance.
// in_stall follows out_stall while a result is held.
// reset clears the occupancy count and the output valid; slot contents are not cleared.
module sorted_array_priority_queue_core #(
  parameter int DEPTH = spq_pkg::SPQ_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic signed [spq_pkg::SPQ_DATA_W-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [spq_pkg::SPQ_DATA_W-1:0] out_removed_value,
  output logic [spq_pkg::SPQ_STAT_W-1:0]        out_status,
  output logic [spq_pkg::SPQ_OCC_W-1:0]         out_occupancy
);
  import spq_pkg::*;

  `include "sorted_array_priority_queue_core_defines.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic                          out_valid_r;
  logic signed [SPQ_DATA_W-1:0]  removed_r;
  logic signed [SPQ_DATA_W-1:0]  removed_nxt;
  spq_stat_t                     status_r;
  spq_stat_t                     status_nxt;
  logic [SPQ_OCC_W-1:0]          occ_r;

  logic                          acc;
  logic                          is_ins;
  logic                          full;
  logic                          empty;
  logic                          cell_we;

  spq_link_t                     links[DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign is_ins   = (in_operation == OP_INSERT);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign cell_we  = acc && (is_ins ? !full : !empty);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_link_t                    prev_l;
      logic signed [SPQ_DATA_W-1:0] next_e;
      if (gi == 0) begin : g_first
        assign prev_l = '{shift: 1'b0, entry: '0};
      end else begin : g_mid
        assign prev_l = links[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_notlast
        assign next_e = links[gi+1].entry;
      end
      spq_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .we         (cell_we),
        .op         (in_operation),
        .ins_value  (in_value),
        .count      (count_r),
        .prev_link  (prev_l),
        .next_entry (next_e),
        .link       (links[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt   = count_r;
    removed_nxt = '0;
    status_nxt  = STAT_OK;
    if (is_ins) begin
      if (full) begin
        status_nxt = STAT_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = STAT_EMPTY;
      end else begin
        count_nxt   = count_r - CNT_W'(1);
        removed_nxt = links[0].entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
      occ_r     <= SPQ_OCC_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_status        = status_r;
  assign out_occupancy     = occ_r;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "occupancy above depth")
  `SPQ_ASSERT_NEXT(a_full_hold, acc && is_ins && full, $stable(count_r), "full insert moved count")
  `SPQ_ASSERT_NEXT(a_result_shown, acc, out_valid_r, "accepted item produced no result")
  `SPQ_ASSERT_NOW(a_sorted_low, count_r >= CNT_W'(2), links[0].entry <= links[1].entry, "unsorted")

endmodule

// ===== sv/spq_cell.sv =====
// one storage slot of the queue, ascending order from slot 0 upward
module spq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic                                 op,
  input  logic signed [spq_pkg::SPQ_DATA_W-1:0] ins_value,
  input  logic [CNT_W-1:0]                     count,
  input  spq_pkg::spq_link_t                   prev_link,
  input  logic signed [spq_pkg::SPQ_DATA_W-1:0] next_entry,
  output spq_pkg::spq_link_t                   link
);
  import spq_pkg::*;

  logic signed [SPQ_DATA_W-1:0] entry_r;
  logic signed [SPQ_DATA_W-1:0] entry_nxt;
  logic                         occ;
  logic                         shift;

  assign occ = CNT_W'(IDX) < count;
  // slot at or above the insert point: the new item lands here or below
  assign shift = !occ || (entry_r >= ins_value);

  always_comb begin
    entry_nxt = entry_r;
    if (op == OP_INSERT) begin
      if (shift) begin
        entry_nxt = prev_link.shift ? prev_link.entry : ins_value;
      end
    end else begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      entry_r <= entry_nxt;
    end
  end

  assign link.shift = shift;
  assign link.entry = entry_r;

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the sorted array priority queue core
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int QDEPTH = SPQ_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [SPQ_DATA_W-1:0] removed;
    spq_stat_t                    status;
    logic [SPQ_OCC_W-1:0]         occupancy;
  } pq_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_operation;
  logic signed [SPQ_DATA_W-1:0] in_value;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SPQ_DATA_W-1:0] out_removed_value;
  logic [SPQ_STAT_W-1:0]        out_status;
  logic [SPQ_OCC_W-1:0]         out_occupancy;

  // predicted queue contents, largest at slot 0, smallest at the tail where removes take it
  logic signed [SPQ_DATA_W-1:0] pq_slots [QDEPTH];
  int unsigned                  pq_fill;
  pq_result_t                   pending_results [$];

  bit send_gaps;
  bit recv_gaps;
  int hold_cycles;
  int items_sent;
  int results_seen;
  int full_refusals;
  int empty_refusals;
  int mismatches;
  int cycle_count;

  sorted_array_priority_queue_core #(.DEPTH(QDEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_removed_value(out_removed_value),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb failed");
      $finish;
    end
  end

  // applies one item to the predicted queue and returns its result
  function automatic pq_result_t apply_to_queue(spq_op_t op, logic signed [SPQ_DATA_W-1:0] v);
    pq_result_t  r;
    int unsigned idx;
    r.removed = '0;
    r.status  = STAT_OK;
    if (op == OP_INSERT) begin
      if (pq_fill >= QDEPTH) begin
        r.status = STAT_FULL;
      end else begin
        idx = pq_fill;
        // the new value goes nearer the tail than equal entries, so it is removed first
        while (idx > 0 && v > pq_slots[idx-1]) begin
          pq_slots[idx] = pq_slots[idx-1];
          idx--;
        end
        pq_slots[idx] = v;
        pq_fill++;
      end
    end else begin
      if (pq_fill == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        pq_fill--;
        r.removed = pq_slots[pq_fill];
      end
    end
    r.occupancy = pq_fill[SPQ_OCC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SPQ_DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input spq_op_t op, input logic signed [SPQ_DATA_W-1:0] v);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_to_queue(op, v));
    items_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    pq_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: removed %0d status %0d occupancy %0d",
                   out_removed_value, out_status, out_occupancy);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status == STAT_FULL) full_refusals++;
        if (exp_r.status == STAT_EMPTY) empty_refusals++;
        if (out_removed_value !== exp_r.removed || out_status !== exp_r.status ||
            out_occupancy !== exp_r.occupancy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: removed %0d/%0d status %0d/%0d occ %0d/%0d",
                     cycle_count, exp_r.removed, out_removed_value, exp_r.status,
                     out_status, exp_r.occupancy, out_occupancy);
        end
      end
    end
  end

  // result side stall, with an occasional long hold-off
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        for (int c = 1; c < hold_cycles; c++) @(negedge clk);
        hold_cycles = 0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  task automatic test_empty_queue();
    send_item(OP_REMOVE, 32'sh7fffffff);
    send_item(OP_REMOVE, 32'sh80000000);
  endtask

  task automatic test_extremes_and_full();
    logic signed [SPQ_DATA_W-1:0] fill_vals [16];
    fill_vals = '{32'sh80000000, 32'sh7fffffff, 0, -1, 1, 32'sh7fffffff, 32'sh80000000, 0,
                  32'sh55555555, 32'shaaaaaaaa, 5, 5, 5, -7, 100, -100};
    foreach (fill_vals[i]) send_item(OP_INSERT, fill_vals[i]);
    // queue is full here, the insert must be refused
    send_item(OP_INSERT, 123);
    repeat (4) send_item(OP_REMOVE, $urandom);
  endtask

  task automatic test_backpressure();
    hold_cycles = 80;
    send_gaps = 1'b0;
    repeat (40) send_item(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_REMOVE, pick_value());
    send_gaps = 1'b1;
  endtask

  // phases lean toward insert or remove so the queue swings between full and empty
  task automatic test_random_mix(input int n_items);
    int insert_pct;
    int left;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0: insert_pct = 90;
        1: insert_pct = 15;
        default: insert_pct = 50;
      endcase
      repeat ($urandom_range(10, 40)) begin
        if (left > 0) begin
          send_item(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE,
                    pick_value());
          left--;
        end
      end
    end
  endtask

  task automatic test_steady_stream();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_mix(60);
  endtask

  initial begin
    int waited;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_INSERT;
    in_value     = '0;
    send_gaps    = 1'b1;
    recv_gaps    = 1'b1;
    hold_cycles  = 0;
    pq_fill      = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    test_extremes_and_full();
    test_backpressure();
    test_random_mix(330);
    test_steady_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
    end

    $display("sent %0d items with random gaps and a long output hold; checked %0d results",
             items_sent, results_seen);
    $display("refused inserts on a full queue: %0d, removes on an empty queue: %0d",
             full_refusals, empty_refusals);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_array_priority_queue_core.sv
bench/tb.sv
